/* rtl/asma_pkg.sv */
// ----------------------------------------------------------------------------
// asma_pkg
// Shared types and constants for the four-channel ADC scaling and
// moving-average filter.
// ----------------------------------------------------------------------------
package asma_pkg;

    localparam int WINDOW_SIZE_DEF = 8;
    localparam int CHANNELS_DEF    = 4;
    localparam int RAW_BITS_DEF    = 10;

    localparam int CH_W   = 2;
    localparam int RAW_W  = 10;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_CURRENT_GAIN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_CURRENT_OFFSET = 2'd1;
    localparam logic [IDX_W-1:0] REG_VOLTAGE_GAIN   = 2'd2;

    localparam logic [31:0] CURRENT_GAIN_RST   = 32'd1731;
    localparam logic [30:0] CURRENT_OFFSET_RST = 31'd885621;
    localparam logic [31:0] VOLTAGE_GAIN_RST   = 32'd320;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [RAW_W-1:0] raw_count;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0]         result_channel;
        logic signed [VAL_W-1:0] filtered_value;
        logic                    window_full;
    } out_item_t;

    // Scaled sample passed from the front part to the back part.
    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic signed [VAL_W-1:0] sample;
    } scaled_t;

endpackage

/* rtl/asma_scale.sv */
// ----------------------------------------------------------------------------
// asma_scale
// Front part: accepts items, drops out-of-range channels, scales the raw
// count to saturated Q16.16 in two stages and pushes into a short queue.
// ----------------------------------------------------------------------------
module asma_scale #(
    parameter int CHANNELS = asma_pkg::CHANNELS_DEF,
    parameter int RAW_BITS = asma_pkg::RAW_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  asma_pkg::in_item_t in_data,
    input  logic [31:0]        current_gain,
    input  logic [30:0]        current_offset,
    input  logic [31:0]        voltage_gain,
    output logic               q_valid,
    input  logic               q_ready,
    output asma_pkg::scaled_t  q_data
);

    localparam int QDEPTH = 2;

    // Stage 1 registers: channel and product.
    logic                     s1_valid_reg;
    logic [asma_pkg::CH_W-1:0] s1_ch_reg;
    logic [41:0]              s1_prod_reg;

    // Queue storage.
    asma_pkg::scaled_t q_mem_reg [QDEPTH];
    logic              q_wp_reg, q_rp_reg;
    logic [1:0]        q_cnt_reg;

    logic              accept, push, pop;
    logic [RAW_BITS-1:0] raw;
    logic [31:0]       gain;
    logic signed [43:0] diff;
    logic signed [31:0] sat;

    assign raw = in_data.raw_count[RAW_BITS-1:0];
    assign gain = in_data.channel[0] ? voltage_gain : current_gain;
    // Only one item in the scaler at a time and the queue must have room
    // counting the one in flight.
    assign in_ready = !s1_valid_reg && (q_cnt_reg < 2'(QDEPTH));
    assign accept = in_valid && in_ready;
    assign push = s1_valid_reg;
    assign pop = q_valid && q_ready;

    // Saturation of the scaled value.
    always_comb
    begin
        if (s1_ch_reg[0])
            diff = $signed({2'b00, s1_prod_reg});
        else
            diff = $signed({2'b00, s1_prod_reg}) - $signed({13'd0, current_offset});
        if (diff > 44'sd2147483647)
            sat = 32'sh7FFFFFFF;
        else if (diff < -44'sd2147483648)
            sat = 32'sh80000000;
        else
            sat = diff[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            q_wp_reg     <= 1'b0;
            q_rp_reg     <= 1'b0;
            q_cnt_reg    <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= accept && (32'(in_data.channel) < CHANNELS);
            if (push)
                q_wp_reg <= !q_wp_reg;
            if (pop)
                q_rp_reg <= !q_rp_reg;
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg   <= in_data.channel;
            s1_prod_reg <= 42'(raw) * 42'(gain);
        end
        if (push)
            q_mem_reg[q_wp_reg] <= '{channel: s1_ch_reg, sample: sat};
    end

    assign q_valid = (q_cnt_reg != 2'd0);
    assign q_data  = q_mem_reg[q_rp_reg];

    a_q_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= 2'(QDEPTH))
        else $error("queue overflow");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_cnt_reg < 2'(QDEPTH)) || pop)
        else $error("push into full queue");

endmodule

/* rtl/asma_window.sv */
// ----------------------------------------------------------------------------
// asma_window
// Back part: per-channel ring update, running sum, and a restoring
// divider of the sum by the fill count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asma_window #(
    parameter int WINDOW_SIZE = asma_pkg::WINDOW_SIZE_DEF,
    parameter int CHANNELS    = asma_pkg::CHANNELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  asma_pkg::scaled_t  q_data,
    output logic               out_valid,
    input  logic               out_ready,
    output asma_pkg::out_item_t out_data
);

    localparam int WI_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int FC_W  = $clog2(WINDOW_SIZE + 1);
    localparam int CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W = 32 + WI_W + 1;
    localparam int DEPTH = CHANNELS * WINDOW_SIZE;
    localparam int AD_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(SUM_W + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [AD_W-1:0] clr_reg;

    logic signed [31:0] ring_mem [DEPTH];
    logic signed [31:0] old_reg;

    logic signed [SUM_W-1:0] sum_reg [CHANNELS];
    logic [WI_W-1:0]         widx_reg [CHANNELS];
    logic [FC_W-1:0]         fill_reg [CHANNELS];

    asma_pkg::scaled_t  cur_reg;
    logic [CI_W-1:0]    ch;
    logic [AD_W-1:0]    addr;
    logic signed [SUM_W-1:0] new_sum;
    logic [FC_W-1:0]    new_fill;

    // Divider registers.
    logic [SUM_W-1:0]   quo_reg;
    logic [FC_W:0]      rem_reg;
    logic [FC_W-1:0]    dvs_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [FC_W:0]      trial;
    logic [SUM_W-1:0]   qfin;

    asma_pkg::out_item_t out_reg;
    logic                out_v_reg;

    assign ch = CI_W'(cur_reg.channel);
    assign addr = AD_W'(32'(ch) * WINDOW_SIZE + 32'(widx_reg[ch]));
    assign new_sum = sum_reg[ch] - SUM_W'(old_reg) + SUM_W'(cur_reg.sample);
    assign new_fill = (fill_reg[ch] < FC_W'(WINDOW_SIZE)) ? fill_reg[ch] + 1'b1 : fill_reg[ch];
    assign trial = {rem_reg[FC_W-1:0], quo_reg[SUM_W-1]};
    assign qfin = neg_reg ? -quo_reg : quo_reg;

    assign q_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            out_v_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]  <= '0;
                widx_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            // The result register is loaded when free or when its item leaves.
            if (state_reg == ST_OUT && (!out_v_reg || out_ready))
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (32'(clr_reg) == DEPTH - 1)
                        state_reg <= ST_IDLE;
                    clr_reg <= clr_reg + 1'b1;
                end
                ST_IDLE:
                    if (q_valid)
                        state_reg <= ST_READ;
                ST_READ:
                    state_reg <= ST_SUM;
                ST_SUM:
                begin
                    sum_reg[ch]  <= new_sum;
                    fill_reg[ch] <= new_fill;
                    widx_reg[ch] <= (32'(widx_reg[ch]) == WINDOW_SIZE - 1) ? '0
                                  : widx_reg[ch] + 1'b1;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                    if (32'(cnt_reg) == SUM_W - 1)
                        state_reg <= ST_OUT;
                ST_OUT:
                    if (!out_v_reg || out_ready)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Ring memory, datapath and divider.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            ring_mem[clr_reg] <= '0;
        if (state_reg == ST_IDLE && q_valid)
            cur_reg <= q_data;
        if (state_reg == ST_READ)
            old_reg <= ring_mem[addr];
        if (state_reg == ST_SUM)
        begin
            ring_mem[addr] <= cur_reg.sample;
            neg_reg <= new_sum[SUM_W-1];
            quo_reg <= new_sum[SUM_W-1] ? -new_sum : new_sum;
            rem_reg <= '0;
            dvs_reg <= new_fill;
            cnt_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (state_reg == ST_OUT && (!out_v_reg || out_ready))
        begin
            out_reg.result_channel <= cur_reg.channel;
            out_reg.filtered_value <= qfin[31:0];
            out_reg.window_full    <= (dvs_reg == FC_W'(WINDOW_SIZE));
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> dvs_reg != '0)
        else $error("divide by zero fill count");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg) == ST_SUM |-> fill_reg[ch] <= FC_W'(WINDOW_SIZE))
        else $error("fill count overrun");

endmodule

/* rtl/adc_scale_moving_average_4ch.sv */
// ----------------------------------------------------------------------------
// adc_scale_moving_average_4ch
// Four-channel ADC scaling and boxcar moving-average filter.
// Path from item accept to result valid, with the back part idle: scaling
// stage, queue write, capture, ring read, sum update, one divider step for
// each of the 36 sum bits, output register.
// The back part takes a new item only when idle, after the bit-serial divider.
// Reset: registers take their reset values; after reset the ring memory,
// all CHANNELS*WINDOW_SIZE entries, is cleared before the back part takes its
// first item, while the front part may already queue items.
// ----------------------------------------------------------------------------
module adc_scale_moving_average_4ch #(
    parameter int WINDOW_SIZE = asma_pkg::WINDOW_SIZE_DEF,
    parameter int CHANNELS    = asma_pkg::CHANNELS_DEF,
    parameter int RAW_BITS    = asma_pkg::RAW_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  asma_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output asma_pkg::out_item_t          out_data,
    input  logic                         cfg_we,
    input  logic [asma_pkg::IDX_W-1:0]   cfg_index,
    input  logic [asma_pkg::CFG_W-1:0]   cfg_data
);

    logic [31:0] current_gain_reg;
    logic [30:0] current_offset_reg;
    logic [31:0] voltage_gain_reg;

    logic              q_valid, q_ready;
    asma_pkg::scaled_t q_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_gain_reg   <= asma_pkg::CURRENT_GAIN_RST;
            current_offset_reg <= asma_pkg::CURRENT_OFFSET_RST;
            voltage_gain_reg   <= asma_pkg::VOLTAGE_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                asma_pkg::REG_CURRENT_GAIN:   current_gain_reg   <= cfg_data;
                asma_pkg::REG_CURRENT_OFFSET: current_offset_reg <= cfg_data[30:0];
                asma_pkg::REG_VOLTAGE_GAIN:   voltage_gain_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    asma_scale #(
        .CHANNELS (CHANNELS),
        .RAW_BITS (RAW_BITS)
    ) u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .current_gain   (current_gain_reg),
        .current_offset (current_offset_reg),
        .voltage_gain   (voltage_gain_reg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_data         (q_data)
    );

    asma_window #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .CHANNELS    (CHANNELS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* sim/asma_checker.sv */
// ----------------------------------------------------------------------------
// asma_checker
// Watches the item and configuration ports of the ADC scaling filter, keeps
// its own copy of the gains, windows and running sums, and compares every
// result item with the mean that it predicts.
// ----------------------------------------------------------------------------
module asma_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  asma_pkg::in_item_t           in_data,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  asma_pkg::out_item_t          out_data,
    input  logic                         cfg_we,
    input  logic [asma_pkg::IDX_W-1:0]   cfg_index,
    input  logic [asma_pkg::CFG_W-1:0]   cfg_data,
    output int                           fail_count,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = asma_pkg::WINDOW_SIZE_DEF;
    localparam int NCH = asma_pkg::CHANNELS_DEF;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic [31:0] cur_gain;
    logic [30:0] cur_offset;
    logic [31:0] volt_gain;

    int     window_vals [NCH][WIN];
    longint window_sum  [NCH];
    int     wr_pos      [NCH];
    int     held        [NCH];

    asma_pkg::out_item_t mean_q [$];

    // Scale one raw count to signed Q16.16 with saturation.
    function automatic int scale_count(logic [asma_pkg::CH_W-1:0] ch,
                                       logic [asma_pkg::RAW_W-1:0] raw);
        longint v;
        if (ch[0] == 1'b0)
            v = longint'({22'd0, raw} * {32'd0, cur_gain})
                - longint'({33'd0, cur_offset});
        else
            v = longint'({22'd0, raw} * {32'd0, volt_gain});
        if (v > SAT_HI)
            v = SAT_HI;
        if (v < SAT_LO)
            v = SAT_LO;
        return int'(v);
    endfunction

    // Push the new value into its channel window and return the mean item.
    function automatic asma_pkg::out_item_t filter_step(asma_pkg::in_item_t it);
        asma_pkg::out_item_t r;
        int        s;
        int        ch;
        longint    mean;
        ch = int'(it.channel);
        s  = scale_count(it.channel, it.raw_count);
        window_sum[ch] = window_sum[ch] - longint'(window_vals[ch][wr_pos[ch]])
                         + longint'(s);
        window_vals[ch][wr_pos[ch]] = s;
        wr_pos[ch] = (wr_pos[ch] + 1 == WIN) ? 0 : wr_pos[ch] + 1;
        if (held[ch] < WIN)
            held[ch]++;
        mean = window_sum[ch] / longint'(held[ch]);
        r.result_channel = it.channel;
        r.filtered_value = mean[31:0];
        r.window_full    = (held[ch] == WIN);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        asma_pkg::out_item_t want;
        if (!rst_n)
        begin
            cur_gain   = asma_pkg::CURRENT_GAIN_RST;
            cur_offset = asma_pkg::CURRENT_OFFSET_RST;
            volt_gain  = asma_pkg::VOLTAGE_GAIN_RST;
            for (int c = 0; c < NCH; c++)
            begin
                window_sum[c] = 0;
                wr_pos[c]     = 0;
                held[c]       = 0;
                for (int k = 0; k < WIN; k++)
                    window_vals[c][k] = 0;
            end
            mean_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // Register writes; index three has no register behind it.
            if (cfg_we)
            begin
                case (cfg_index)
                    asma_pkg::REG_CURRENT_GAIN:   cur_gain   = cfg_data;
                    asma_pkg::REG_CURRENT_OFFSET: cur_offset = cfg_data[30:0];
                    asma_pkg::REG_VOLTAGE_GAIN:   volt_gain  = cfg_data;
                    default: ;
                endcase
            end
            // Every accepted item yields exactly one result item.
            if (in_valid && in_ready)
                mean_q.push_back(filter_step(in_data));
            // Compare the result item with the oldest prediction.
            if (out_valid && out_ready)
            begin
                if (mean_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result item ch=%0d val=%0d full=%0b",
                                 $realtime, out_data.result_channel,
                                 out_data.filtered_value, out_data.window_full);
                end
                else
                begin
                    want = mean_q.pop_front();
                    if (out_data.result_channel !== want.result_channel ||
                        out_data.filtered_value !== want.filtered_value ||
                        out_data.window_full !== want.window_full)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: mismatch exp ch=%0d val=%0d full=%0b, ",
                                      "got ch=%0d val=%0d full=%0b"},
                                     $realtime, want.result_channel, want.filtered_value,
                                     want.window_full, out_data.result_channel,
                                     out_data.filtered_value, out_data.window_full);
                    end
                end
            end
            pending = mean_q.size();
        end
    end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives directed and random ADC items through the scaling filter under
// several gain and offset settings, with random gaps on the sender and
// random stalls on the receiver; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [asma_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int WATCH_LIMIT = 4000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    asma_pkg::in_item_t           in_data = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    asma_pkg::out_item_t          out_data;
    logic                         cfg_we = 1'b0;
    logic [asma_pkg::IDX_W-1:0]   cfg_index = '0;
    logic [asma_pkg::CFG_W-1:0]   cfg_data = '0;
    int                           fail_count;
    int                           pending;
    int                           stall_mode = 0;
    logic                         gaps_on = 1'b1;
    int                           quiet_cycles = 0;

    always #5 clk = ~clk;

    adc_scale_moving_average_4ch u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    asma_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    // Receiver stalls; mode zero never stalls.
    always @(posedge clk)
    begin
        if (stall_mode == 0)
            out_ready <= 1'b1;
        else
            out_ready <= (pick_gap() == 0);
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("adc_scale_moving_average_4ch verification failed");
            $finish;
        end
    end

    task automatic send_item(logic [asma_pkg::CH_W-1:0] ch,
                             logic [asma_pkg::RAW_W-1:0] raw);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{channel: ch, raw_count: raw};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Let every result drain, plus the block's latency, before touching registers.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic load_regs(logic [31:0] cg, logic [31:0] co, logic [31:0] vg);
        cfg_we    <= 1'b1;
        cfg_index <= asma_pkg::REG_CURRENT_GAIN;
        cfg_data  <= cg;
        @(posedge clk);
        cfg_index <= asma_pkg::REG_CURRENT_OFFSET;
        cfg_data  <= co;
        @(posedge clk);
        cfg_index <= asma_pkg::REG_VOLTAGE_GAIN;
        cfg_data  <= vg;
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= $urandom();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random items; a few come at the extremes of the count.
    task automatic random_items(int count);
        logic [asma_pkg::RAW_W-1:0] raw;
        int                         r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 9);
            raw = (r == 0) ? '0 : (r == 1) ? '1 : asma_pkg::RAW_W'($urandom());
            send_item(asma_pkg::CH_W'($urandom()), raw);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset gains, zero and full-scale counts on every channel,
        // then enough items on channel zero to wrap its window.
        stall_mode = 0;
        gaps_on    = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            send_item(asma_pkg::CH_W'(c), '0);
            send_item(asma_pkg::CH_W'(c), '1);
        end
        for (int k = 0; k < 10; k++)
            send_item(asma_pkg::CH_W'(0), (k % 2 == 0) ? 10'h3FF : 10'h155);
        wait_idle();

        // Largest gains with no offset: both kinds of channel saturate high.
        load_regs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        for (int k = 0; k < 5; k++)
            send_item(asma_pkg::CH_W'(k % 4), '1);
        gaps_on    = 1'b1;
        stall_mode = 1;
        random_items(160);
        wait_idle();

        // Zero gains with the largest offset: current channels go far negative.
        load_regs(32'd0, 32'h7FFF_FFFF, 32'd0);
        random_items(180);
        wait_idle();

        // Back to the reset values.
        load_regs(asma_pkg::CURRENT_GAIN_RST, {1'b0, asma_pkg::CURRENT_OFFSET_RST},
                  asma_pkg::VOLTAGE_GAIN_RST);
        stall_mode = 0;
        gaps_on    = 1'b0;
        random_items(150);
        wait_idle();

        // Random settings; gains near the saturation edge and ordinary ones.
        for (int p = 0; p < 5; p++)
        begin
            load_regs((p % 2 == 0) ? $urandom_range(0, 32'h0020_0000) : $urandom(),
                      $urandom() >> 1 >> (p * 3), $urandom_range(0, 32'h0040_0000));
            stall_mode = p % 2;
            gaps_on    = (p != 2);
            random_items(190);
            wait_idle();
        end

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("adc_scale_moving_average_4ch verification clean");
        else
            $display("adc_scale_moving_average_4ch verification failed");
        $finish;
    end

endmodule
